// ----- src/bwc_pkg.sv -----
// Shared types, widths, constants and helper functions for the barycentric weight unit.
// Depends on nothing; every other file imports it.
package bwc_pkg;

	localparam int COORD_BITS       = 24;
	localparam int COORD_FRAC_BITS  = 8;
	localparam int WEIGHT_FRAC_BITS = 16;
	localparam int WEIGHT_BITS      = 32;
	localparam int THR_BITS         = 20;
	localparam int THR_FRAC_BITS    = 16;
	localparam int THR_RESET        = 655;

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int SUM_W   = CROSS_W + 1;
	localparam int MAG_W   = SUM_W;
	localparam int DEN_W   = CROSS_W;
	// Quotient magnitude bits kept; anything at or above 2^Q_W saturates its weight.
	localparam int Q_W     = WEIGHT_BITS + 2;
	localparam int QS_W    = Q_W + 2;
	localparam int OVF_SH  = Q_W - WEIGHT_FRAC_BITS;
	localparam int DIV_LAT = Q_W + 2;
	localparam int CMP_L   = DEN_W + THR_FRAC_BITS;
	localparam int CMP_R   = THR_BITS + 2 * COORD_FRAC_BITS;
	localparam int CMP_W   = (CMP_L > CMP_R) ? CMP_L : CMP_R;

	typedef logic signed [COORD_BITS-1:0]  coord_t;
	typedef logic signed [WEIGHT_BITS-1:0] weight_t;
	typedef logic [THR_BITS-1:0]           thr_t;
	typedef logic signed [CROSS_W-1:0]     cross_t;
	typedef logic signed [SUM_W-1:0]       sum_t;
	typedef logic [MAG_W-1:0]              mag_t;
	typedef logic [DEN_W-1:0]              den_t;
	typedef logic [Q_W-1:0]                quo_t;
	typedef logic signed [QS_W-1:0]        quo_s_t;

	typedef struct packed {
		logic   valid;
		cross_t kx;
		cross_t ky;
		cross_t kz;
	} cross_res_t;

	typedef struct packed {
		quo_t q;
		logic ovf;
		logic neg;
	} div_res_t;

	typedef struct packed {
		logic valid;
		logic degen;
	} side_t;

	localparam weight_t W_ONE     = weight_t'(64'(1) << WEIGHT_FRAC_BITS);
	localparam weight_t W_NEG_ONE = -W_ONE;
	localparam weight_t W_MAX     = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
	localparam weight_t W_MIN     = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

	function automatic mag_t abs_sum(sum_t v);
		return v[SUM_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

	// Clamp a signed quotient-width value to the signed weight range.
	function automatic weight_t sat_w(quo_s_t v);
		logic all_zero;
		logic all_one;
		all_zero = ~|v[QS_W-1:WEIGHT_BITS-1];
		all_one  = &v[QS_W-1:WEIGHT_BITS-1];
		if (all_zero || all_one) begin
			return v[WEIGHT_BITS-1:0];
		end
		return v[QS_W-1] ? W_MIN : W_MAX;
	endfunction

endpackage

// ----- src/bwc_cross.sv -----
// Edge vectors, products and cross product of the triangle, three pipeline stages.
// Depends on bwc_pkg.
module bwc_cross (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  bwc_pkg::coord_t     ax,
	input  bwc_pkg::coord_t     ay,
	input  bwc_pkg::coord_t     bx,
	input  bwc_pkg::coord_t     by,
	input  bwc_pkg::coord_t     cx,
	input  bwc_pkg::coord_t     cy,
	input  bwc_pkg::coord_t     px,
	input  bwc_pkg::coord_t     py,
	output bwc_pkg::cross_res_t res
);
	import bwc_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic signed [DIFF_W-1:0] acx_s1, acy_s1, abx_s1, aby_s1, pax_s1, pay_s1;
	logic signed [PROD_W-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	cross_t kx_s3, ky_s3, kz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acx_s1 <= DIFF_W'(cx) - DIFF_W'(ax);
			acy_s1 <= DIFF_W'(cy) - DIFF_W'(ay);
			abx_s1 <= DIFF_W'(bx) - DIFF_W'(ax);
			aby_s1 <= DIFF_W'(by) - DIFF_W'(ay);
			pax_s1 <= DIFF_W'(ax) - DIFF_W'(px);
			pay_s1 <= DIFF_W'(ay) - DIFF_W'(py);
			p0_s2  <= abx_s1 * pay_s1;
			p1_s2  <= pax_s1 * aby_s1;
			p2_s2  <= pax_s1 * acy_s1;
			p3_s2  <= acx_s1 * pay_s1;
			p4_s2  <= acx_s1 * aby_s1;
			p5_s2  <= abx_s1 * acy_s1;
			kx_s3  <= CROSS_W'(p0_s2) - CROSS_W'(p1_s2);
			ky_s3  <= CROSS_W'(p2_s2) - CROSS_W'(p3_s2);
			kz_s3  <= CROSS_W'(p4_s2) - CROSS_W'(p5_s2);
		end
	end

	assign res = '{valid: v_s3, kx: kx_s3, ky: ky_s3, kz: kz_s3};

endmodule

// ----- src/bwc_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, with an early overflow check.
// Depends on bwc_pkg.
module bwc_div (
	input  logic              clk,
	input  logic              en,
	input  bwc_pkg::mag_t     mag,
	input  bwc_pkg::den_t     den,
	input  logic              neg,
	output bwc_pkg::div_res_t res
);
	import bwc_pkg::*;

	localparam int OW    = (MAG_W > DEN_W + OVF_SH) ? MAG_W : DEN_W + OVF_SH;
	localparam int N_W   = MAG_W + WEIGHT_FRAC_BITS;
	localparam int REM_W = DEN_W + 1;

	mag_t mag_sa;
	den_t den_sa;
	logic neg_sa;
	logic [N_W-1:0] nfull;

	den_t rem_sk [0:Q_W-1];
	quo_t low_sk [0:Q_W-1];
	den_t den_sk [0:Q_W-1];
	quo_t q_sk   [0:Q_W];
	logic ovf_sk [0:Q_W];
	logic neg_sk [0:Q_W];

	assign nfull = {mag_sa, {WEIGHT_FRAC_BITS{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			mag_sa    <= mag;
			den_sa    <= den;
			neg_sa    <= neg;
			// The quotient reaches 2^Q_W exactly when mag >= den * 2^(Q_W - frac bits).
			ovf_sk[0] <= OW'(mag_sa) >= (OW'(den_sa) << OVF_SH);
			rem_sk[0] <= DEN_W'(nfull >> Q_W);
			low_sk[0] <= nfull[Q_W-1:0];
			den_sk[0] <= den_sa;
			q_sk[0]   <= '0;
			neg_sk[0] <= neg_sa;
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [REM_W-1:0] trial;
		logic             take;

		assign trial = {rem_sk[k], low_sk[k][Q_W-1]};
		assign take  = trial >= REM_W'(den_sk[k]);

		always_ff @(posedge clk) begin
			if (en) begin
				q_sk[k+1]   <= {q_sk[k][Q_W-2:0], take};
				ovf_sk[k+1] <= ovf_sk[k];
				neg_sk[k+1] <= neg_sk[k];
			end
		end

		if (k < Q_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_sk[k+1] <= take ? DEN_W'(trial - REM_W'(den_sk[k])) : DEN_W'(trial);
					low_sk[k+1] <= low_sk[k] << 1;
					den_sk[k+1] <= den_sk[k];
				end
			end
		end
	end

	assign res = '{q: q_sk[Q_W], ovf: ovf_sk[Q_W], neg: neg_sk[Q_W]};

endmodule

// ----- src/triangle_barycentric_weights_unit.sv -----
// Top level of the triangle barycentric weight unit: cross product, threshold, dividers, output.
// Depends on bwc_pkg, bwc_cross and bwc_div.
//
// Usage. One input beat carries the x and y coordinates of vertices A, B, C and of a
// query point P, signed with 8 fraction bits. One output beat per input beat carries
// the weights of A, B and C, signed with 16 fraction bits and saturated to 32 bits,
// plus a degenerate flag. When the cross product z magnitude is at or below the
// programmed threshold the beat carries -1, 1, 1 and the flag is set.
// Both data channels use valid and stall; a beat moves when valid is high and stall
// is low. The threshold is written on its own valid/ready channel, which is always
// ready; write it only while the pipeline is empty.
// From input beat to output beat the pipeline has three cross product stages,
// a sum stage, an absolute value and threshold stage, 36 stages in each of the three
// dividers (one quotient bit per stage, 34 bits) and the output register.
// Throughput is one beat per cycle unless an output beat is held; the dividers are
// fully pipelined. A stall on a valid output beat freezes the whole pipeline in place,
// so the input channel stalls in the same cycle and nothing is dropped or repeated.
// Reset clears all valid bits and loads the threshold with 655 (about 0.01).
module triangle_barycentric_weights_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  bwc_pkg::coord_t  vertex_a_x,
	input  bwc_pkg::coord_t  vertex_a_y,
	input  bwc_pkg::coord_t  vertex_b_x,
	input  bwc_pkg::coord_t  vertex_b_y,
	input  bwc_pkg::coord_t  vertex_c_x,
	input  bwc_pkg::coord_t  vertex_c_y,
	input  bwc_pkg::coord_t  point_x,
	input  bwc_pkg::coord_t  point_y,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  bwc_pkg::thr_t    degenerate_threshold,
	output logic             out_valid,
	input  logic             out_stall,
	output bwc_pkg::weight_t weight_a,
	output bwc_pkg::weight_t weight_b,
	output bwc_pkg::weight_t weight_c,
	output logic             degenerate
);
	import bwc_pkg::*;

	logic       en;
	thr_t       thr_q;
	cross_res_t cres;

	// Sum stage.
	logic   v_s4;
	sum_t   sum_s4;
	cross_t kx_s4, ky_s4, kz_s4;

	// Absolute value and threshold stage.
	logic v_s5, degen_s5;
	mag_t mag_a_s5, mag_b_s5, mag_c_s5;
	den_t den_s5;
	logic neg_a_s5, neg_b_s5, neg_c_s5;
	den_t den_abs;

	side_t    side_sd [0:DIV_LAT-1];
	div_res_t dres_a, dres_b, dres_c;

	quo_t   qa_abs, qb_abs, qc_abs;
	quo_s_t qa, qb, qc, wa_full;

	logic    out_valid_q, degen_q;
	weight_t wa_q, wb_q, wc_q;

	// The whole pipeline advances together unless a finished beat is held at the output.
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= thr_t'(THR_RESET);
		end else if (cfg_valid) begin
			thr_q <= degenerate_threshold;
		end
	end

	bwc_cross u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.ax       (vertex_a_x),
		.ay       (vertex_a_y),
		.bx       (vertex_b_x),
		.by       (vertex_b_y),
		.cx       (vertex_c_x),
		.cy       (vertex_c_y),
		.px       (point_x),
		.py       (point_y),
		.res      (cres)
	);

	assign den_abs = DEN_W'(abs_sum(SUM_W'(kz_s4)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= cres.valid;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4   <= SUM_W'(cres.kx) + SUM_W'(cres.ky);
			kx_s4    <= cres.kx;
			ky_s4    <= cres.ky;
			kz_s4    <= cres.kz;
			// Weight A divides kx+ky, weight B divides ky, weight C divides kx.
			mag_a_s5 <= abs_sum(sum_s4);
			mag_b_s5 <= abs_sum(SUM_W'(ky_s4));
			mag_c_s5 <= abs_sum(SUM_W'(kx_s4));
			den_s5   <= den_abs;
			neg_a_s5 <= sum_s4[SUM_W-1] ^ kz_s4[CROSS_W-1];
			neg_b_s5 <= ky_s4[CROSS_W-1] ^ kz_s4[CROSS_W-1];
			neg_c_s5 <= kx_s4[CROSS_W-1] ^ kz_s4[CROSS_W-1];
			// Both sides are scaled to the same fraction so the compare is exact.
			degen_s5 <= CMP_W'({den_abs, {THR_FRAC_BITS{1'b0}}})
				<= CMP_W'({thr_q, {(2*COORD_FRAC_BITS){1'b0}}});
		end
	end

	bwc_div u_div_a (.clk(clk), .en(en), .mag(mag_a_s5), .den(den_s5), .neg(neg_a_s5),
		.res(dres_a));
	bwc_div u_div_b (.clk(clk), .en(en), .mag(mag_b_s5), .den(den_s5), .neg(neg_b_s5),
		.res(dres_b));
	bwc_div u_div_c (.clk(clk), .en(en), .mag(mag_c_s5), .den(den_s5), .neg(neg_c_s5),
		.res(dres_c));

	// Valid and degenerate flags ride alongside the dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				side_sd[i] <= '0;
			end
		end else if (en) begin
			side_sd[0] <= '{valid: v_s5, degen: degen_s5};
			for (int i = 1; i < DIV_LAT; i++) begin
				side_sd[i] <= side_sd[i-1];
			end
		end
	end

	assign qa_abs  = dres_a.q;
	assign qb_abs  = dres_b.q;
	assign qc_abs  = dres_c.q;
	assign qa      = dres_a.neg ? -quo_s_t'({2'b00, qa_abs}) : quo_s_t'({2'b00, qa_abs});
	assign qb      = dres_b.neg ? -quo_s_t'({2'b00, qb_abs}) : quo_s_t'({2'b00, qb_abs});
	assign qc      = dres_c.neg ? -quo_s_t'({2'b00, qc_abs}) : quo_s_t'({2'b00, qc_abs});
	assign wa_full = quo_s_t'(W_ONE) - qa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= side_sd[DIV_LAT-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_q <= side_sd[DIV_LAT-1].degen;
			if (side_sd[DIV_LAT-1].degen) begin
				wa_q <= W_NEG_ONE;
				wb_q <= W_ONE;
				wc_q <= W_ONE;
			end else begin
				// A quotient of 2^34 or more is past every weight limit; the sign picks the rail.
				if (dres_a.ovf) begin
					wa_q <= dres_a.neg ? W_MAX : W_MIN;
				end else begin
					wa_q <= sat_w(wa_full);
				end
				if (dres_b.ovf) begin
					wb_q <= dres_b.neg ? W_MIN : W_MAX;
				end else begin
					wb_q <= sat_w(qb);
				end
				if (dres_c.ovf) begin
					wc_q <= dres_c.neg ? W_MIN : W_MAX;
				end else begin
					wc_q <= sat_w(qc);
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign weight_a   = wa_q;
	assign weight_b   = wb_q;
	assign weight_c   = wc_q;
	assign degenerate = degen_q;

	// A degenerate beat always carries the fixed invalid triple.
	a_degen_triple: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |->
			(weight_a == W_NEG_ONE && weight_b == W_ONE && weight_c == W_ONE))
		else $error("degenerate beat without the invalid triple");

	// While the output is held, the pipeline interior must not move.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> ($stable(v_s4) && $stable(v_s5) && $stable(side_sd[0])))
		else $error("pipeline moved during a stall");

	// The threshold changes only through a configuration write.
	a_thr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_valid |=> $stable(thr_q))
		else $error("threshold changed without a write");

endmodule

// ----- verif/tb_triangle_barycentric_weights_unit.sv -----
// Self-checking bench for triangle_barycentric_weights_unit: predicts weights per beat.
// Depends on bwc_pkg and the RTL of triangle_barycentric_weights_unit.
module tb_triangle_barycentric_weights_unit;
	import bwc_pkg::*;

	// One expected output beat.
	typedef struct {
		weight_t wa;
		weight_t wb;
		weight_t wc;
		logic    degen;
	} weights_t;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_stall;
	coord_t  vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y;
	coord_t  vertex_c_x, vertex_c_y, point_x, point_y;
	logic    cfg_valid;
	logic    cfg_ready;
	thr_t    degenerate_threshold;
	logic    out_valid;
	logic    out_stall;
	weight_t weight_a, weight_b, weight_c;
	logic    degenerate;

	// The testbench's own copy of the threshold register.
	thr_t     thr_model;
	weights_t pending_weights[$];
	int       mismatch_count;
	int       idle_cycles;
	bit       timed_out;
	bit       jitter_on;
	bit       out_stall_burst;

	localparam int PIPE_LAT  = 42;
	localparam int IDLE_MAX  = 2000;

	triangle_barycentric_weights_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.vertex_a_x(vertex_a_x), .vertex_a_y(vertex_a_y),
		.vertex_b_x(vertex_b_x), .vertex_b_y(vertex_b_y),
		.vertex_c_x(vertex_c_x), .vertex_c_y(vertex_c_y),
		.point_x(point_x), .point_y(point_y),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.degenerate_threshold(degenerate_threshold),
		.out_valid(out_valid), .out_stall(out_stall),
		.weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c),
		.degenerate(degenerate)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Saturate a wide signed value to the 32-bit weight range.
	function automatic weight_t clamp_weight(logic signed [127:0] v);
		if (v > 128'sd2147483647) begin
			return 32'sh7fffffff;
		end
		if (v < -128'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Quotient (num * 2^16) / den truncated toward zero; SystemVerilog division
	// on signed operands already truncates toward zero.
	function automatic logic signed [127:0] scaled_ratio(logic signed [127:0] num,
			logic signed [127:0] den);
		logic signed [127:0] shifted;
		shifted = num * 128'sd65536;
		return shifted / den;
	endfunction

	// Predict one beat of weights from the eight coordinates and the threshold.
	function automatic weights_t predict_weights(coord_t ax, coord_t ay, coord_t bx,
			coord_t by, coord_t cx, coord_t cy, coord_t px, coord_t py, thr_t thr);
		logic signed [127:0] acx, acy, abx, aby, pax, pay;
		logic signed [127:0] kx, ky, kz, mag_z, one;
		weights_t r;
		acx = 128'(cx) - 128'(ax);
		acy = 128'(cy) - 128'(ay);
		abx = 128'(bx) - 128'(ax);
		aby = 128'(by) - 128'(ay);
		pax = 128'(ax) - 128'(px);
		pay = 128'(ay) - 128'(py);
		kx = abx * pay - pax * aby;
		ky = pax * acy - acx * pay;
		kz = acx * aby - abx * acy;
		mag_z = (kz < 0) ? -kz : kz;
		one = 128'sd65536;
		// Both sides carry 32 fraction bits once |z| is shifted by 16 and the
		// threshold by twice the coordinate fraction.
		if ((mag_z <<< THR_FRAC_BITS) <= (128'(thr) <<< (2 * COORD_FRAC_BITS))) begin
			r.wa = W_NEG_ONE;
			r.wb = W_ONE;
			r.wc = W_ONE;
			r.degen = 1'b1;
		end else begin
			r.wa = clamp_weight(one - scaled_ratio(kx + ky, kz));
			r.wb = clamp_weight(scaled_ratio(ky, kz));
			r.wc = clamp_weight(scaled_ratio(kx, kz));
			r.degen = 1'b0;
		end
		return r;
	endfunction

	// Send one beat and queue its expected weights when it is accepted.
	// Valid stays high after acceptance so the next beat can follow at once.
	task automatic send_triangle(coord_t ax, coord_t ay, coord_t bx, coord_t by,
			coord_t cx, coord_t cy, coord_t px, coord_t py);
		int gap;
		if (jitter_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		vertex_a_x <= ax;
		vertex_a_y <= ay;
		vertex_b_x <= bx;
		vertex_b_y <= by;
		vertex_c_x <= cx;
		vertex_c_y <= cy;
		point_x    <= px;
		point_y    <= py;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		pending_weights.push_back(predict_weights(ax, ay, bx, by, cx, cy, px, py,
			thr_model));
	endtask

	// Wait until every expected beat has come, then let the pipe run empty.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_weights.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	// Write the threshold register; the pipeline must be empty.
	task automatic write_threshold(thr_t value);
		drain_pipeline();
		cfg_valid            <= 1'b1;
		degenerate_threshold <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		thr_model = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic coord_t random_coord();
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom_range(0, 1) ? 24'h7fffff : 24'h800000);
			1: return coord_t'($urandom_range(0, 4095)) - 12'sd2048;
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic coord_t nudge(coord_t base);
		return base + coord_t'($urandom_range(0, 6)) - coord_t'(3);
	endfunction

	// Extremes of every field, a collinear triangle, a point on a vertex,
	// and tiny triangles with a far point, which fall under the reset threshold.
	task automatic test_directed();
		send_triangle(0, 0, 256, 0, 0, 256, 64, 64);
		send_triangle(0, 0, 256, 0, 0, 256, 256, 0);
		send_triangle(0, 0, 256, 0, 0, 256, 0, 0);
		send_triangle(0, 0, 256, 256, 512, 512, 100, 7);
		send_triangle(0, 0, 0, 0, 0, 0, 0, 0);
		send_triangle(24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh800000,
			24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
		send_triangle(24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh7fffff,
			24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh800000);
		send_triangle(0, 0, 1, 0, 0, 2, 24'sh7fffff, 24'sh800000);
		send_triangle(0, 0, 3, 0, 0, 3, 24'sh800000, 24'sh7fffff);
		send_triangle(-5, -5, 2, -5, -5, 2, 1, 1);
		send_triangle(24'sh555555, 24'shaaaaaa, 24'shaaaaaa, 24'sh555555,
			24'sh123456, 24'shfedcba, 24'sh0f0f0f, 24'shf0f0f0);
	endtask

	// Threshold at each extreme and near the boundary of the degenerate compare.
	task automatic test_threshold_extremes();
		write_threshold(0);
		send_triangle(0, 0, 1, 0, 0, 1, 0, 0);
		send_triangle(0, 0, 0, 0, 5, 5, 1, 1);
		write_threshold(thr_t'(20'hfffff));
		send_triangle(0, 0, 256, 0, 0, 256, 10, 10);
		send_triangle(0, 0, 4096, 0, 0, 4096, 10, 10);
		send_triangle(0, 0, 4097, 0, 0, 4096, 10, 10);
		// z of 2^16 (a unit triangle) against threshold 1.0 and just under it.
		write_threshold(thr_t'(20'h10000));
		send_triangle(0, 0, 256, 0, 0, 256, 3, 3);
		write_threshold(thr_t'(20'h0ffff));
		send_triangle(0, 0, 256, 0, 0, 256, 3, 3);
		write_threshold(thr_t'(THR_RESET));
	endtask

	// Small triangles with a nearby point so weights stay in range, full-range noise
	// (half of all triangles) and near-collinear ones that hit the degenerate path.
	task automatic test_random(int count);
		coord_t ax, ay, bx, by, cx, cy, px, py;
		for (int i = 0; i < count; i++) begin
			ax = random_coord();
			ay = random_coord();
			case ($urandom_range(0, 3))
				0: begin
					bx = ax + coord_t'($urandom_range(0, 8191)) - 13'sd4096;
					by = ay + coord_t'($urandom_range(0, 8191)) - 13'sd4096;
					cx = ax + coord_t'($urandom_range(0, 8191)) - 13'sd4096;
					cy = ay + coord_t'($urandom_range(0, 8191)) - 13'sd4096;
					px = ax + coord_t'($urandom_range(0, 8191)) - 13'sd4096;
					py = ay + coord_t'($urandom_range(0, 8191)) - 13'sd4096;
				end
				1: begin
					bx = nudge(ax);
					by = nudge(ay);
					cx = nudge(ax);
					cy = nudge(ay);
					px = random_coord();
					py = random_coord();
				end
				default: begin
					bx = random_coord();
					by = random_coord();
					cx = random_coord();
					cy = random_coord();
					px = random_coord();
					py = random_coord();
				end
			endcase
			send_triangle(ax, ay, bx, by, cx, cy, px, py);
		end
	endtask

	// Checker: compare each output beat with the oldest prediction.
	always @(posedge clk) begin
		weights_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_weights.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected beat: a=%0d b=%0d c=%0d degenerate=%0b",
						weight_a, weight_b, weight_c, degenerate);
				end
			end else begin
				exp_w = pending_weights.pop_front();
				if (weight_a !== exp_w.wa || weight_b !== exp_w.wb ||
						weight_c !== exp_w.wc || degenerate !== exp_w.degen) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("weights differ: exp a=%0d b=%0d c=%0d deg=%0b",
							exp_w.wa, exp_w.wb, exp_w.wc, exp_w.degen);
						$display("                got a=%0d b=%0d c=%0d deg=%0b",
							weight_a, weight_b, weight_c, degenerate);
					end
				end
			end
		end
	end

	// Receiver stalls in random bursts while jitter is on.
	always @(posedge clk) begin
		if (!jitter_on) begin
			out_stall <= 1'b0;
		end else if (idle_cycles > 0) begin
			out_stall <= out_stall_burst;
		end
	end

	int stall_left;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else begin
			stall_left = $urandom_range(1, 10);
			out_stall_burst = jitter_on && ($urandom_range(0, 2) == 0);
		end
	end

	// Watchdog: ends the run after too many cycles with no beat accepted.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 1;
		end else if (idle_cycles >= IDLE_MAX) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n               = 1'b0;
		in_valid             = 1'b0;
		vertex_a_x           = '0;
		vertex_a_y           = '0;
		vertex_b_x           = '0;
		vertex_b_y           = '0;
		vertex_c_x           = '0;
		vertex_c_y           = '0;
		point_x              = '0;
		point_y              = '0;
		cfg_valid            = 1'b0;
		degenerate_threshold = '0;
		out_stall            = 1'b0;
		thr_model            = thr_t'(THR_RESET);
		mismatch_count       = 0;
		idle_cycles          = 1;
		stall_left           = 0;
		out_stall_burst      = 1'b0;
		jitter_on            = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_threshold_extremes();
		test_random(200);
		// Sender holds off here until every result is back.
		drain_pipeline();
		write_threshold(thr_t'($urandom_range(1, 20'hffffe)));
		test_random(200);
		write_threshold(thr_t'(THR_RESET));
		// Closing stretch at full rate with no idling on either side.
		jitter_on = 1'b0;
		test_random(130);
		drain_pipeline();

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/bwc_pkg.sv
src/bwc_cross.sv
src/bwc_div.sv
src/triangle_barycentric_weights_unit.sv
verif/tb_triangle_barycentric_weights_unit.sv
